FILE: hw/rtl/lqni_pkg.sv
// Shared types, constants and the sequencer microcode for the LCD nibble interface.
package lqni_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 128;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = 10;

  // Input action codes
  localparam logic [1:0] ACT_POLL  = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_INSTR = 2'd2;

  // Queue entry kinds (entry bits 9..8)
  localparam logic [1:0] KIND_FULL = 2'd0;
  localparam logic [1:0] KIND_HIGH = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_SENT  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_DROP  = 2'd3;

  // Port byte constants
  localparam logic [7:0] PORT_READ_STROBE = 8'hC0;

  // Nibble select in a control word
  localparam logic [1:0] NIB_NONE = 2'd0;
  localparam logic [1:0] NIB_HI   = 2'd1;
  localparam logic [1:0] NIB_LO   = 2'd2;

  // Jump conditions
  localparam logic [1:0] JC_NONE = 2'd0;
  localparam logic [1:0] JC_BUSY = 2'd1;
  localparam logic [1:0] JC_HIGH = 2'd2;

  // Microprogram step addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_BR0   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_BR1   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_BR2   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_BR3   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_BR4   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_HI0   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_HI1   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_HI2   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LO0   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_LO1   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LO2   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SENT  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_BUSY  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_EMPTY = 4'd13;
  localparam logic [STEP_W-1:0] STEP_DROP  = 4'd14;

  // Channel payloads
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       high_nibble_only;
    logic       busy_flag;
  } in_item_t;

  typedef struct packed {
    logic       port_write;
    logic [7:0] port_value;
    logic       port_reading;
    logic       busy_sample;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One microcode control word
  typedef struct packed {
    logic              port_write;
    logic              en;
    logic              rd;
    logic              reading;
    logic              sample;
    logic [1:0]        nib;
    logic [1:0]        status;
    logic              last;
    logic [1:0]        jcond;
    logic [STEP_W-1:0] jtarget;
    logic              ram_re;
    logic              deq;
  } ctrl_t;

  function automatic ctrl_t mk(input logic wr, input logic en, input logic rd,
                               input logic reading, input logic sample,
                               input logic [1:0] nib, input logic [1:0] status,
                               input logic last, input logic [1:0] jcond,
                               input logic [STEP_W-1:0] jtarget,
                               input logic ram_re, input logic deq);
    ctrl_t c;
    c.port_write = wr;
    c.en         = en;
    c.rd         = rd;
    c.reading    = reading;
    c.sample     = sample;
    c.nib        = nib;
    c.status     = status;
    c.last       = last;
    c.jcond      = jcond;
    c.jtarget    = jtarget;
    c.ram_re     = ram_re;
    c.deq        = deq;
    return c;
  endfunction

  // Microcode ROM: busy-read strobes, upper nibble, lower nibble, status
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t c;
    case (s)
      STEP_BR0:   c = mk(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, NIB_NONE, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b1, 1'b0);
      STEP_BR1:   c = mk(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, NIB_NONE, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_BR2:   c = mk(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, NIB_NONE, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_BR3:   c = mk(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, NIB_NONE, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_BR4:   c = mk(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, NIB_NONE, ST_EMPTY, 1'b0,
                         JC_BUSY, STEP_BUSY, 1'b0, 1'b0);
      STEP_HI0:   c = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NIB_HI, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b1);
      STEP_HI1:   c = mk(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NIB_HI, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_HI2:   c = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NIB_HI, ST_EMPTY, 1'b0,
                         JC_HIGH, STEP_SENT, 1'b0, 1'b0);
      STEP_LO0:   c = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NIB_LO, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_LO1:   c = mk(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NIB_LO, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_LO2:   c = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NIB_LO, ST_EMPTY, 1'b0,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_SENT:  c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NIB_NONE, ST_SENT, 1'b1,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_BUSY:  c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NIB_NONE, ST_BUSY, 1'b1,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_EMPTY: c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NIB_NONE, ST_EMPTY, 1'b1,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      STEP_DROP:  c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NIB_NONE, ST_DROP, 1'b1,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
      default:    c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NIB_NONE, ST_EMPTY, 1'b1,
                         JC_NONE, STEP_BR0, 1'b0, 1'b0);
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/lqni_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lqni_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/lcd_queued_nibble_interface_unit.sv
// Top level: queued 4-bit character LCD interface driven by a microcoded sequencer.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------
//   in      | input     | in_valid/in_stall | in_item_t
//   out     | output    | out_valid/out_stall | out_item_t
//
// An item gives one result per cycle while the output is not stalled: 1 result for a
// drop or empty status, 6 for a busy status, 9 or 12 for a sent entry (12 results at most).
// The next item is taken in the cycle the final result is loaded into the
// output register, so the microcode step counter sets the rate.
// Reset clears the queue indices, the count and the sequencer; the queue RAM
// is not cleared. A stalled output freezes the sequencer in place.
module lcd_queued_nibble_interface_unit import lqni_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              run_r, run_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  ctrl_t             cw;
  logic              adv;
  logic              in_xfer;
  logic              enq;
  logic              full;
  logic              enq_ok;
  logic [1:0]        new_kind;
  logic [ENTRY_W-1:0] rd_entry;
  logic [1:0]        rd_kind;
  logic [7:0]        rd_byte;
  logic [3:0]        nib_val;
  logic              rs_bit;
  logic              jump;
  logic [STEP_W-1:0] start_step;

  // Microcode fetch and sequencer advance
  assign cw       = ucode(step_r);
  assign adv      = run_r & (~out_valid_r | ~out_stall);
  assign in_stall = run_r & ~(adv & cw.last);
  assign in_xfer  = in_valid & ~in_stall;

  // Enqueue decode
  assign enq      = in_xfer & ((in_data.action == ACT_CHAR) | (in_data.action == ACT_INSTR));
  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign enq_ok   = enq & ~full;
  assign new_kind = (in_data.action == ACT_CHAR) ? KIND_CHAR :
                    (in_data.high_nibble_only ? KIND_HIGH : KIND_FULL);

  // First microcode step for a new item
  always_comb begin
    if (enq & full) begin
      start_step = STEP_DROP;
    end else if (~enq_ok && (cnt_r == '0)) begin
      start_step = STEP_EMPTY;
    end else begin
      start_step = STEP_BR0;
    end
  end

  // Pending queue storage
  lqni_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (enq_ok),
    .waddr(wr_idx_r),
    .wdata({new_kind, in_data.data_byte}),
    .re   (adv & cw.ram_re),
    .raddr(rd_idx_r),
    .rdata(rd_entry)
  );

  assign rd_kind = rd_entry[9:8];
  assign rd_byte = rd_entry[7:0];

  // Datapath: nibble select and register select
  always_comb begin
    case (cw.nib)
      NIB_HI:  nib_val = rd_byte[7:4];
      NIB_LO:  nib_val = rd_byte[3:0];
      default: nib_val = 4'h0;
    endcase
  end
  assign rs_bit = (cw.nib != NIB_NONE) && (rd_kind == KIND_CHAR);

  // Conditional jump
  always_comb begin
    case (cw.jcond)
      JC_BUSY: jump = busy_r;
      JC_HIGH: jump = (rd_kind == KIND_HIGH);
      default: jump = 1'b0;
    endcase
  end

  // Next-state logic
  always_comb begin
    run_nxt       = run_r;
    step_nxt      = step_r;
    busy_nxt      = busy_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Output register drains on transfer
    if (out_valid_r & ~out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Emit one result per step
    if (adv) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.port_write = cw.port_write;
      // bit7 enable, bit6 read, bit5 register select, bits 3..0 data
      out_data_nxt.port_value = {cw.en, cw.rd, rs_bit, 1'b0, nib_val};
      out_data_nxt.port_reading = cw.reading;
      out_data_nxt.busy_sample  = cw.sample;
      out_data_nxt.status       = cw.status;
      out_data_nxt.last         = cw.last;
      step_nxt = jump ? cw.jtarget : step_r + 1'b1;
      if (cw.last) begin
        run_nxt = 1'b0;
      end
      if (cw.deq) begin
        rd_idx_nxt = (rd_idx_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
        cnt_nxt    = cnt_r - 1'b1;
      end
    end

    // New item
    if (in_xfer) begin
      run_nxt  = 1'b1;
      step_nxt = start_step;
      busy_nxt = in_data.busy_flag;
      if (enq_ok) begin
        wr_idx_nxt = (wr_idx_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      step_r      <= STEP_BR0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      step_r      <= step_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    busy_r     <= busy_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/lqni_checker.sv
// Port-level assertions for the LCD nibble interface, bound to the top level.
module lqni_checker import lqni_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every result before the final one is a port write with no status
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.port_write && out_data.status == ST_EMPTY)
    else $error("non-final result is not a plain port write");

  // Final result is status only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !out_data.port_write && out_data.port_value == 8'h00 &&
      !out_data.port_reading && !out_data.busy_sample)
    else $error("status result carries port data");

  // Busy is sampled only on a read strobe with enable high
  a_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.busy_sample |->
      out_data.port_reading && out_data.port_value == PORT_READ_STROBE)
    else $error("busy sample on a wrong port write");

  // Nibble writes never assert read or the unused data bit
  a_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.port_write && !out_data.port_reading |->
      !out_data.port_value[6] && !out_data.port_value[4])
    else $error("nibble write with read or bit 4 set");

endmodule

bind lcd_queued_nibble_interface_unit lqni_checker u_lqni_checker (.*);
